>>> src/ssv_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the save-journal
// stream validator. No dependencies; every other file uses it by scoped name.
package ssv_pkg;

  // Reflected CRC-32, preset and final xor all ones
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

  // Header layout
  localparam int HEADER_BYTES   = 24;
  localparam logic [31:0] FORMAT_VERSION = 32'd1;
  // Magic bytes in file order, byte 0 in the low lane
  localparam logic [31:0] MAGIC_WORD = 32'h31444447;

  // Configuration register indexes
  localparam logic REG_SOURCE_HASH = 1'b0;
  localparam logic REG_DISK_SIZE   = 1'b1;

  // Output queue, depth is a power of two and at least 4
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_LW    = FIFO_AW + 1;

  typedef enum logic [2:0] {
    ST_LOADED     = 3'd0,
    ST_TRUNCATED  = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_CRC    = 3'd4,
    ST_HASH_MISMATCH = 3'd5,
    ST_BAD_RANGE  = 3'd6
  } status_t;

  // One result item
  typedef struct packed {
    logic        is_final;
    status_t     status;
    logic [31:0] record_count;
    logic [31:0] byte_address;
    logic [7:0]  byte_value;
  } result_t;

  // Items produced by one input transaction; first is always used first
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [FIFO_LW-1:0] level;
    logic               room2;
  } fifo_stat_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/ssv_parser.sv
// Parse state, header checks and running CRC for the stream validator.
// Depends on ssv_pkg; one registered input byte is consumed per advance.
module ssv_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          file_byte,
  input  logic                end_of_file,
  input  logic [63:0]         source_hash,
  input  logic [31:0]         disk_size,
  output ssv_pkg::push_t      push
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_FIELDS  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_SKIP    = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_TRUNC = 2'd1,
    FAULT_RANGE = 2'd2
  } fault_t;

  typedef struct packed {
    logic hash_bad;
    logic version_bad;
    logic magic_bad;
  } checks_t;

  logic [4:0]  header_position, header_position_next;
  logic [31:0] crc_running, crc_running_next;
  logic [31:0] stored_checksum, stored_checksum_next;
  checks_t     header_checks, header_checks_next;
  logic [63:0] field_shift, field_shift_next;
  logic [31:0] records_declared, records_declared_next;
  logic [31:0] records_done, records_done_next;
  logic [31:0] record_start, record_start_next;
  logic [31:0] payload_left, payload_left_next;
  phase_t      parse_phase, parse_phase_next;
  fault_t      record_fault, record_fault_next;

  logic [31:0]      word;
  logic [7:0]       crc_data;
  logic             emit_payload;
  logic [32:0]      record_end;
  ssv_pkg::status_t st;
  ssv_pkg::result_t payload_item, status_item;

  always_comb begin
    header_position_next  = header_position;
    crc_running_next      = crc_running;
    stored_checksum_next  = stored_checksum;
    header_checks_next    = header_checks;
    records_declared_next = records_declared;
    records_done_next     = records_done;
    record_start_next     = record_start;
    payload_left_next     = payload_left;
    parse_phase_next      = parse_phase;
    record_fault_next     = record_fault;
    emit_payload          = 1'b0;

    field_shift_next = {file_byte, field_shift[63:8]};
    word             = field_shift_next[63:32];
    record_end       = {1'b0, record_start} + {1'b0, word};

    // Header bytes 20..23 hold the checksum and enter the CRC as zero
    crc_data = file_byte;
    if (parse_phase == PH_HEADER && header_position >= 5'd20 && header_position <= 5'd23) begin
      crc_data = 8'h00;
    end
    crc_running_next = ssv_pkg::crc32_byte(crc_running, crc_data);

    case (parse_phase)
      PH_HEADER: begin
        if (header_position < 5'd4 &&
            file_byte != ssv_pkg::MAGIC_WORD[header_position[1:0]*8 +: 8]) begin
          header_checks_next.magic_bad = 1'b1;
        end
        if (header_position == 5'd7 && word != ssv_pkg::FORMAT_VERSION) begin
          header_checks_next.version_bad = 1'b1;
        end
        if (header_position == 5'd15 && field_shift_next != source_hash) begin
          header_checks_next.hash_bad = 1'b1;
        end
        if (header_position == 5'd19) begin
          records_declared_next = word;
        end
        if (header_position == 5'(ssv_pkg::HEADER_BYTES - 1)) begin
          stored_checksum_next = word;
          header_position_next = 5'd0;
          parse_phase_next     = (records_declared == 32'd0) ? PH_DONE : PH_FIELDS;
        end else begin
          header_position_next = header_position + 5'd1;
        end
      end
      PH_FIELDS: begin
        // Offset in bytes 0..3, length in bytes 4..7
        if (header_position[2:0] == 3'd3) begin
          record_start_next = word;
        end
        if (header_position[2:0] == 3'd7) begin
          payload_left_next    = word;
          header_position_next = 5'd0;
          if (word == 32'd0) begin
            record_fault_next = FAULT_TRUNC;
            parse_phase_next  = PH_DONE;
          end else if (record_end > {1'b0, disk_size}) begin
            parse_phase_next = PH_SKIP;
          end else begin
            parse_phase_next = PH_PAYLOAD;
          end
        end else begin
          header_position_next = {2'b00, header_position[2:0] + 3'd1};
        end
      end
      PH_PAYLOAD: begin
        emit_payload      = 1'b1;
        record_start_next = record_start + 32'd1;
        payload_left_next = payload_left - 32'd1;
        if (payload_left == 32'd1) begin
          records_done_next = records_done + 32'd1;
          if (records_done_next == records_declared) begin
            parse_phase_next = PH_DONE;
          end else begin
            parse_phase_next     = PH_FIELDS;
            header_position_next = 5'd0;
          end
        end
      end
      PH_SKIP: begin
        payload_left_next = payload_left - 32'd1;
        if (payload_left == 32'd1) begin
          record_fault_next = FAULT_RANGE;
          parse_phase_next  = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Final status from the updated state, in precedence order
  always_comb begin
    if (parse_phase_next == PH_HEADER) begin
      st = ssv_pkg::ST_TRUNCATED;
    end else if (header_checks_next.magic_bad) begin
      st = ssv_pkg::ST_BAD_MAGIC;
    end else if (header_checks_next.version_bad) begin
      st = ssv_pkg::ST_BAD_VERSION;
    end else if ((crc_running_next ^ ssv_pkg::ALL_ONES) != stored_checksum_next) begin
      st = ssv_pkg::ST_BAD_CRC;
    end else if (header_checks_next.hash_bad) begin
      st = ssv_pkg::ST_HASH_MISMATCH;
    end else if (record_fault_next == FAULT_TRUNC) begin
      st = ssv_pkg::ST_TRUNCATED;
    end else if (record_fault_next == FAULT_RANGE) begin
      st = ssv_pkg::ST_BAD_RANGE;
    end else if (parse_phase_next != PH_DONE) begin
      st = ssv_pkg::ST_TRUNCATED;
    end else begin
      st = ssv_pkg::ST_LOADED;
    end
  end

  // Build the items for this byte; payload goes ahead of the status
  always_comb begin
    payload_item              = '0;
    payload_item.byte_address = record_start;
    payload_item.byte_value   = file_byte;

    status_item              = '0;
    status_item.is_final     = 1'b1;
    status_item.status       = st;
    status_item.record_count = records_done_next;

    push        = '0;
    if (advance) begin
      if (emit_payload) begin
        push.first  = payload_item;
        push.second = status_item;
        push.count  = end_of_file ? 2'd2 : 2'd1;
      end else begin
        push.first  = status_item;
        push.count  = end_of_file ? 2'd1 : 2'd0;
      end
    end
  end

  // State update; the last byte of a file returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (advance && end_of_file)) begin
      header_position  <= 5'd0;
      crc_running      <= ssv_pkg::ALL_ONES;
      stored_checksum  <= 32'd0;
      header_checks    <= '0;
      field_shift      <= 64'd0;
      records_declared <= 32'd0;
      records_done     <= 32'd0;
      record_start     <= 32'd0;
      payload_left     <= 32'd0;
      parse_phase      <= PH_HEADER;
      record_fault     <= FAULT_NONE;
    end else if (advance) begin
      header_position  <= header_position_next;
      crc_running      <= crc_running_next;
      stored_checksum  <= stored_checksum_next;
      header_checks    <= header_checks_next;
      field_shift      <= field_shift_next;
      records_declared <= records_declared_next;
      records_done     <= records_done_next;
      record_start     <= record_start_next;
      payload_left     <= payload_left_next;
      parse_phase      <= parse_phase_next;
      record_fault     <= record_fault_next;
    end
  end

endmodule

>>> src/ssv_out_fifo.sv
// Small result queue that takes up to two items per cycle and gives one per pop.
// Depends on ssv_pkg for the item type and depth.
module ssv_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  ssv_pkg::push_t       push,
  input  logic                 pop,
  output ssv_pkg::result_t     head,
  output logic                 head_valid,
  output ssv_pkg::fifo_stat_t  stat
);

  ssv_pkg::result_t mem [ssv_pkg::FIFO_DEPTH];

  logic [ssv_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [ssv_pkg::FIFO_LW-1:0] level, level_next;
  logic [ssv_pkg::FIFO_AW-1:0] wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + ssv_pkg::FIFO_AW'(1);
  assign head         = mem[rd_ptr];
  assign head_valid   = (level != '0);
  assign level_next   = level + {{(ssv_pkg::FIFO_LW-2){1'b0}}, push.count}
                              - {{(ssv_pkg::FIFO_LW-1){1'b0}}, pop};

  assign stat.level = level;
  assign stat.room2 = (level <= ssv_pkg::FIFO_LW'(ssv_pkg::FIFO_DEPTH - 2));

  // Storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_plus1] <= push.second;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ssv_pkg::FIFO_AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + ssv_pkg::FIFO_AW'(1);
      end
      level <= level_next;
    end
  end

endmodule

>>> src/save_sidecar_stream_validator_top.sv
// Top level of the save-journal stream validator: configuration registers,
// input register stage, parser and result queue. Depends on ssv_pkg,
// ssv_parser and ssv_out_fifo.
//
// The block takes one file byte per cycle and gives at most one result item
// per cycle while out_stall is low; a byte is held in the input register and
// its results go through the result queue to the output. The rate is set by
// the combinational CRC-32 byte update and field shift in the parser. The
// last byte of a file that also carries a payload byte yields two items,
// which the four-entry queue absorbs; the input stalls only while it is near full.
// Payload items may be committed only after the final item reports loaded.
// Registers: index 0 is the expected 64-bit fingerprint, index 1 the disk
// size in bytes; write them only while no transaction is in flight.
module save_sidecar_stream_validator_top (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_final,
  output logic [2:0]  status,
  output logic [31:0] record_count,
  output logic [31:0] byte_address,
  output logic [7:0]  byte_value
);

  logic [63:0] source_hash;
  logic [31:0] disk_size;

  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        stage_eof;
  logic        advance;
  logic        in_accept;

  ssv_pkg::push_t      push;
  ssv_pkg::result_t    head;
  ssv_pkg::fifo_stat_t fifo_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_hash <= 64'd0;
      disk_size   <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        ssv_pkg::REG_SOURCE_HASH: source_hash <= cfg_data;
        ssv_pkg::REG_DISK_SIZE:   disk_size   <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage moves on when the queue has room for two items
  assign advance   = stage_valid && fifo_stat.room2;
  assign in_stall  = stage_valid && !fifo_stat.room2;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_byte <= file_byte;
      stage_eof  <= end_of_file;
    end
  end

  ssv_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .file_byte   (stage_byte),
    .end_of_file (stage_eof),
    .source_hash (source_hash),
    .disk_size   (disk_size),
    .push        (push)
  );

  ssv_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (out_valid && !out_stall),
    .head       (head),
    .head_valid (out_valid),
    .stat       (fifo_stat)
  );

  assign is_final     = head.is_final;
  assign status       = head.status;
  assign record_count = head.record_count;
  assign byte_address = head.byte_address;
  assign byte_value   = head.byte_value;

`ifndef ASSERT_OFF
  // Queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_stat.level <= ssv_pkg::FIFO_LW'(ssv_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // The last byte of a file always yields a final item as its last result
  a_eof_status: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_eof) |->
      ((push.count == 2'd1 && push.first.is_final) ||
       (push.count == 2'd2 && push.second.is_final && !push.first.is_final)))
    else $error("end of file without final status");

  // Other bytes yield at most one payload item
  a_mid_payload: assert property (@(posedge clk) disable iff (rst)
    (advance && !stage_eof) |-> (push.count == 2'd0 ||
      (push.count == 2'd1 && !push.first.is_final)))
    else $error("unexpected item for a mid-file byte");

  // Nothing is pushed without a byte moving through
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !advance |-> (push.count == 2'd0))
    else $error("item pushed without input");
`endif

endmodule
